### design/sorted_priority_queue_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue core
// Shared property shapes, clocked on the core clock and idle during reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/spq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Entry, control and channel types plus status and request kind codes.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_W          = 16;
   localparam int SCORE_W       = 18;
   localparam int OCC_W         = 5;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_POPPED   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]    unit_id;
      logic [ID_W-1:0]    unit_capacity;
      logic [ID_W-1:0]    unit_space;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } ctl_type;

   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    unit_id;
      logic [ID_W-1:0]    unit_capacity;
      logic [ID_W-1:0]    unit_space;
      logic [SCORE_W-1:0] priority_score;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] out_id;
      logic [ID_W-1:0] out_capacity;
      logic [ID_W-1:0] out_space;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

endpackage

### design/spq_cell.sv
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one slot; shifts toward the tail on insert and toward the head on pop.
// ---------------------------------------------------------------------------
module spq_cell (
   input  logic               clock,
   input  spq_pkg::ctl_type   ctl,
   input  logic               occupied,
   input  logic               left_shift,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               shift,
   output spq_pkg::entry_type entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Flag slots at or past the insert position (empty or score not below key)
   assign shift = !occupied || (entry_ff.score >= ctl.entry.score);

   // Take the new entry at the insert position, the left neighbor past it,
   // the right neighbor on pop; otherwise hold
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && shift) begin
         entry_in = left_shift ? left_entry : ctl.entry;
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### design/sorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// Sorted priority queue core: rsp_valid rises in the cycle after a request is accepted.
// Throughput 1 request per cycle while rsp_ready does not stall; every cell of the slot row updates at once.
// Reset clears the entry count and the response valid; slot data is not cleared.
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
   parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_payload
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spq_pkg::rsp_type   rsp_ff;
   spq_pkg::rsp_type   rsp_in;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   spq_pkg::ctl_type   ctl;
   logic [COUNT_W+4:0] occ_ext;

   spq_pkg::entry_type     cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_shift;
   logic [QUEUE_DEPTH-1:0] cell_occ;

   // Accept while the response register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);

   // Broadcast the command to the cell row
   always_comb begin
      ctl.insert              = accept && (req_payload.kind == spq_pkg::KIND_INSERT) && !is_full;
      ctl.pop                 = accept && (req_payload.kind == spq_pkg::KIND_POP) && !is_empty;
      ctl.entry.unit_id       = req_payload.unit_id;
      ctl.entry.unit_capacity = req_payload.unit_capacity;
      ctl.entry.unit_space    = req_payload.unit_space;
      ctl.entry.score         = req_payload.priority_score;
   end

   // Build the row of slot cells, head at index zero
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_pkg::entry_type right_entry;
      logic               left_shift;
      spq_pkg::entry_type left_entry;

      assign cell_occ[i] = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_head
         assign left_shift = 1'b0;
         assign left_entry = ctl.entry;
      end else begin : g_body
         assign left_shift = cell_shift[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_next
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (cell_occ[i]),
         .left_shift  (left_shift),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .shift       (cell_shift[i]),
         .entry       (cell_entry[i])
      );
   end

   // Advance the entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   assign occ_ext = {5'b0, count_in};

   // Form the response for the accepted request
   always_comb begin
      rsp_in.out_id       = '0;
      rsp_in.out_capacity = '0;
      rsp_in.out_space    = '0;
      rsp_in.occupancy    = occ_ext[spq_pkg::OCC_W-1:0];
      if (req_payload.kind == spq_pkg::KIND_INSERT) begin
         rsp_in.status = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else if (is_empty) begin
         rsp_in.status = spq_pkg::ST_EMPTY;
      end else begin
         rsp_in.status       = spq_pkg::ST_POPPED;
         rsp_in.out_id       = cell_entry[0].unit_id;
         rsp_in.out_capacity = cell_entry[0].unit_capacity;
         rsp_in.out_space    = cell_entry[0].unit_space;
      end
   end

   // Hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= COUNT_W'(QUEUE_DEPTH), "entry count above depth")
   `SPQ_ASSERT_NEXT(a_pop_count, ctl.pop, count_ff == $past(count_ff) - COUNT_W'(1), "pop did not drop count")
   `SPQ_ASSERT_NEXT(a_pop_status, ctl.pop, rsp_valid_ff && rsp_ff.status == spq_pkg::ST_POPPED, "pop without popped response")
   `SPQ_ASSERT_SAME(a_empty_zero, rsp_valid_ff && rsp_ff.status == spq_pkg::ST_EMPTY, rsp_ff.out_id == '0 && rsp_ff.occupancy == '0, "empty pop response not zero")

endmodule

### test/sorted_priority_queue_core_tb.sv
// ---------------------------------------------------------------------------
// Sorted priority queue core testbench
// Sends insert and pop requests with random pacing on both channels. Keeps
// its own ordered copy of the held entries and checks each response field.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core_tb;

   localparam int DEPTH       = spq_pkg::DEPTH_DEFAULT;
   localparam int ID_W        = spq_pkg::ID_W;
   localparam int SCORE_W     = spq_pkg::SCORE_W;
   localparam int OCC_W       = spq_pkg::OCC_W;
   localparam int HALF_CYCLE  = 4;
   localparam int RANDOM_REQS = 1650;

   typedef struct {
      spq_pkg::req_type payload;
      int unsigned      gap;
   } paced_req_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   spq_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   spq_pkg::rsp_type rsp_payload;

   // Request backlog, pacing and response bookkeeping
   paced_req_type    req_backlog[$];
   spq_pkg::rsp_type rsp_due[$];
   paced_req_type    staged_req;
   bit               staged     = 1'b0;
   int unsigned      gap_left   = 0;
   int unsigned      ready_hold = 0;
   bit               rsp_calm   = 1'b0;
   int unsigned      mismatches = 0;
   int unsigned      rsp_seen   = 0;

   // Predicted queue contents, head at index 0
   spq_pkg::entry_type held[DEPTH];
   int                 held_count = 0;
   int                 peak_count = 0;
   int unsigned        n_inserted = 0;
   int unsigned        n_popped   = 0;
   int unsigned        n_empty    = 0;
   int unsigned        n_dropped  = 0;

   sorted_priority_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #HALF_CYCLE clock = ~clock;

   // Apply one request to the predicted queue and return its response
   function automatic spq_pkg::rsp_type predict_response(spq_pkg::req_type rq);
      spq_pkg::rsp_type rs;
      int               pos;
      rs = '0;
      if (rq.kind == spq_pkg::KIND_INSERT) begin
         if (held_count >= DEPTH) begin
            rs.status = spq_pkg::ST_FULL;
            n_dropped++;
         end else begin
            // new entry goes ahead of every equal or greater score
            pos = 0;
            while (pos < held_count && held[pos].score < rq.priority_score) pos++;
            for (int i = held_count; i > pos; i--) held[i] = held[i - 1];
            held[pos].unit_id       = rq.unit_id;
            held[pos].unit_capacity = rq.unit_capacity;
            held[pos].unit_space    = rq.unit_space;
            held[pos].score         = rq.priority_score;
            held_count++;
            if (held_count > peak_count) peak_count = held_count;
            rs.status = spq_pkg::ST_INSERTED;
            n_inserted++;
         end
      end else if (held_count == 0) begin
         rs.status = spq_pkg::ST_EMPTY;
         n_empty++;
      end else begin
         rs.status       = spq_pkg::ST_POPPED;
         rs.out_id       = held[0].unit_id;
         rs.out_capacity = held[0].unit_capacity;
         rs.out_space    = held[0].unit_space;
         for (int i = 1; i < held_count; i++) held[i - 1] = held[i];
         held_count--;
         n_popped++;
      end
      rs.occupancy = OCC_W'(held_count);
      return rs;
   endfunction

   function automatic void queue_req(logic kind, logic [ID_W-1:0] id,
                                     logic [ID_W-1:0] cap, logic [ID_W-1:0] space,
                                     logic [SCORE_W-1:0] score, int unsigned gap);
      paced_req_type p;
      p.payload.kind           = kind;
      p.payload.unit_id        = id;
      p.payload.unit_capacity  = cap;
      p.payload.unit_space     = space;
      p.payload.priority_score = score;
      p.gap                    = gap;
      req_backlog.push_back(p);
   endfunction

   function automatic logic [ID_W-1:0] pick_field();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      return ID_W'($urandom);
   endfunction

   // Scores from a small pool give ties and close neighbors
   function automatic logic [SCORE_W-1:0] pick_score(bit ties);
      if (ties || $urandom_range(0, 99) < 30) begin
         case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return SCORE_W'(1);
            3: return SCORE_W'(18'h20000);
            default: return SCORE_W'($urandom_range(2, 5));
         endcase
      end
      return SCORE_W'($urandom);
   endfunction

   // Mostly short stalls, a few long ones
   function automatic int unsigned pick_stall();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_gap(bit calm);
      if (calm || $urandom_range(0, 99) < 55) return 0;
      return pick_stall();
   endfunction

   function automatic void flag_mismatch(string field, longint unsigned want,
                                         longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d at response %0d, %s: expected 0x%0h, got 0x%0h",
                  mismatches, rsp_seen, field, want, got);
   endfunction

   // Present backlog requests; predict each one at its handshake
   always @(posedge clock) begin : req_driver
      logic fired;
      logic keep;
      if (reset) begin
         req_valid <= 1'b0;
         staged     = 1'b0;
      end else begin
         fired = req_valid && req_ready;
         if (fired) rsp_due.push_back(predict_response(req_payload));
         keep = req_valid && !fired;
         if (!keep && !staged && req_backlog.size() != 0) begin
            staged_req = req_backlog.pop_front();
            staged     = 1'b1;
            gap_left   = staged_req.gap;
         end
         // hold off for the request's gap, then raise valid
         if (!keep && staged) begin
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               req_payload <= staged_req.payload;
               staged       = 1'b0;
               keep         = 1'b1;
            end
         end
         req_valid <= keep;
      end
   end

   // Check responses in order and stall the response channel at random
   always @(posedge clock) begin : rsp_monitor
      spq_pkg::rsp_type want;
      logic             next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (rsp_due.size() == 0) begin
               flag_mismatch("unexpected response, status", 0, rsp_payload.status);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", want.status, rsp_payload.status);
               if (rsp_payload.out_id !== want.out_id)
                  flag_mismatch("out_id", want.out_id, rsp_payload.out_id);
               if (rsp_payload.out_capacity !== want.out_capacity)
                  flag_mismatch("out_capacity", want.out_capacity, rsp_payload.out_capacity);
               if (rsp_payload.out_space !== want.out_space)
                  flag_mismatch("out_space", want.out_space, rsp_payload.out_space);
               if (rsp_payload.occupancy !== want.occupancy)
                  flag_mismatch("occupancy", want.occupancy, rsp_payload.occupancy);
            end
         end
         if (ready_hold == 0 && !rsp_calm && $urandom_range(0, 99) < 35)
            ready_hold = pick_stall();
         if (ready_hold != 0) begin
            ready_hold--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         // switch between stalling and free-running stretches
         if ($urandom_range(0, 299) == 0) rsp_calm = !rsp_calm;
         rsp_ready <= next_ready;
      end
   end

   initial begin : stimulus
      int unsigned made;
      int unsigned phase_len;
      int unsigned lean;
      bit          calm;
      bit          ties;
      logic        kind;

      // Pop on an empty queue, unused fields all ones
      queue_req(spq_pkg::KIND_POP, '1, '1, '1, '1, 0);
      // Field and score extremes
      queue_req(spq_pkg::KIND_INSERT, '1, '0, '1, '1, 0);
      queue_req(spq_pkg::KIND_INSERT, '0, '1, '0, '0, 0);
      // Equal scores: the newest is served first
      queue_req(spq_pkg::KIND_INSERT, 16'h1111, 16'h2222, 16'h3333, '0, 0);
      queue_req(spq_pkg::KIND_INSERT, 16'h5a5a, 16'ha5a5, 16'h0f0f, 18'h20000, 0);
      queue_req(spq_pkg::KIND_INSERT, 16'ha5a5, 16'h5a5a, 16'hf0f0, 18'h20000, 0);
      queue_req(spq_pkg::KIND_INSERT, 16'h0001, 16'h0002, 16'h0003, 18'h00001, 0);
      queue_req(spq_pkg::KIND_INSERT, '1, '1, '1, '1, 0);
      // Drain everything, then pop empty again with zero fields
      for (int n = 0; n < 7; n++) queue_req(spq_pkg::KIND_POP, '0, '0, '0, '0, 0);
      queue_req(spq_pkg::KIND_POP, '0, '0, '0, '0, 0);
      queue_req(spq_pkg::KIND_INSERT, 16'h8000, 16'h0001, 16'h8000, 18'h10000, 0);
      queue_req(spq_pkg::KIND_POP, 16'h7fff, 16'hfffe, 16'h7fff, 18'h0ffff, 0);

      // Random phases: balanced, fill-heavy, drain-heavy or insert-leaning mixes, some tie-heavy
      made = 0;
      while (made < RANDOM_REQS) begin
         phase_len = $urandom_range(40, 160);
         case ($urandom_range(0, 3))
            0: lean = 50;
            1: lean = 85;
            2: lean = 15;
            default: lean = 60;
         endcase
         ties = ($urandom_range(0, 3) == 0);
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_len && made < RANDOM_REQS; n++) begin
            kind = ($urandom_range(0, 99) < lean) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_POP;
            queue_req(kind, pick_field(), pick_field(), pick_field(), pick_score(ties),
                      pick_gap(calm));
            made++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain the backlog and every outstanding response
      while (req_backlog.size() != 0 || staged || req_valid) @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d inserts, %0d pops, %0d pops on empty, %0d drops on full",
               n_inserted, n_popped, n_empty, n_dropped);
      $display("deepest occupancy %0d of %0d; %0d responses checked, %0d mismatches",
               peak_count, DEPTH, rsp_seen, mismatches);
      if (mismatches == 0) begin
         $display("sorted_priority_queue_core_tb: PASS");
      end else begin
         $display("sorted_priority_queue_core_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("timeout with %0d responses still due", rsp_due.size());
      $display("sorted_priority_queue_core_tb: FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_tb.sv
